// ===== design/gte_pkg.sv =====
// Package for the geodetic to earth-centred conversion core.
// Holds shared word types, ellipsoid and angle constants, and elaboration-time helpers.
// No dependencies.
package gte_pkg;

  typedef logic [63:0]        word_t;
  typedef logic signed [63:0] sword_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SEMI_MAJOR = 1'b0,
    CFG_ECC_SQ     = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_W      = 40;
  localparam int unsigned AXIS_W     = 33;
  localparam int unsigned ECC_W      = 40;
  localparam int unsigned HEIGHT_W   = 28;
  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned COORD_W    = 34;

  localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
  localparam logic [ECC_W-1:0]  ECC_RESET  = 40'd7360548640;

  localparam word_t PI_Q61      = 64'h6487ED5110B4611A;
  localparam word_t ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam word_t THREE_Q60   = 64'h3000_0000_0000_0000;
  localparam word_t ONE_Q54     = 64'h0040_0000_0000_0000;
  localparam word_t THREE_Q54   = 64'h00C0_0000_0000_0000;
  localparam word_t W2_FLOOR    = 64'h0000_1000_0000_0000;
  localparam word_t ONE_Q40     = 64'h0000_0100_0000_0000;
  localparam word_t SAT_MAG     = 64'h4000_0000_0000_0000;
  localparam word_t OUT_LIMIT   = 64'd6600000000;
  localparam word_t MM_ROUND    = 64'h0000_0000_0008_0000;

  // Newton steps for the inverse square root of w2.
  localparam int unsigned NEWTON_STEPS = 24;

  // round(a*b / 2^sh), ties up, low 64 bits of the result.
  function automatic word_t umulr_c(word_t a, word_t b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return p[63:0];
  endfunction

  // Restoring division, used only for elaboration-time constants.
  function automatic word_t udiv_c(word_t n, word_t d);
    word_t rem;
    word_t q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rotation angle atan(2^-i) in Q60 from a truncated Taylor series.
  function automatic sword_t atan_q60(int unsigned i);
    sword_t      sum;
    word_t       term;
    int unsigned k;
    sum = '0;
    if (i == 0) begin
      sum = sword_t'(PI_Q61 >> 3);
    end else if (i < 60) begin
      k = 0;
      while (i * (2 * k + 1) <= 60) begin
        term = udiv_c(64'd1 << (60 - i * (2 * k + 1)), word_t'(2 * k + 1));
        if (k[0]) sum = sum - sword_t'(term);
        else      sum = sum + sword_t'(term);
        k++;
      end
    end
    return sum;
  endfunction

  // Start value of x: inverse of the rotation gain, in Q60.
  function automatic word_t cordic_start(int unsigned stages);
    word_t g;
    word_t y;
    word_t t;
    word_t u;
    g = 64'd1 << 62;
    y = 64'd1 << 59;
    for (int unsigned i = 0; i < stages; i++) begin
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    for (int i = 0; i < 8; i++) begin
      t = umulr_c(y, y, 60);
      u = umulr_c(g, t, 62);
      y = umulr_c(y, THREE_Q60 - u, 61);
    end
    return y;
  endfunction

  // Apply a sign to a magnitude, clamping the magnitude at 2^62.
  function automatic word_t with_sign(logic neg, word_t m);
    word_t mc;
    mc = (m > SAT_MAG) ? SAT_MAG : m;
    return neg ? (64'd0 - mc) : mc;
  endfunction

  // Q20 value to whole millimetres, ties away from zero, saturated.
  function automatic logic [COORD_W-1:0] to_mm(word_t v);
    word_t m;
    word_t r;
    m = v[63] ? (64'd0 - v) : v;
    m = (m + MM_ROUND) >> 20;
    if (m > OUT_LIMIT) m = OUT_LIMIT;
    r = v[63] ? (64'd0 - m) : m;
    return r[COORD_W-1:0];
  endfunction

endpackage

// ===== design/gte_mulr.sv =====
// Pipelined 64 by 64 multiplier with rounding shift, optionally sign-magnitude.
// Carries a payload and a valid bit alongside. Depends on gte_pkg.
module gte_mulr #(
  parameter int unsigned SH  = 60,
  parameter int unsigned PW  = 1,
  parameter bit          SGN = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              valid_i,
  input  gte_pkg::word_t    a_i,
  input  gte_pkg::word_t    b_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output gte_pkg::word_t    res_o,
  output logic [PW-1:0]     pay_o
);
  import gte_pkg::*;

  localparam logic [127:0] RND = 128'd1 << (SH - 1);

  logic          va;
  word_t         am;
  word_t         bm;
  logic          nega;
  logic [PW-1:0] paya;

  // Optional front stage: operand magnitudes and result sign.
  if (SGN) begin : g_sign
    logic          va_r;
    word_t         am_r;
    word_t         bm_r;
    logic          neg_r;
    logic [PW-1:0] pay_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
      end else if (ce) begin
        va_r <= valid_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        am_r  <= a_i[63] ? (64'd0 - a_i) : a_i;
        bm_r  <= b_i[63] ? (64'd0 - b_i) : b_i;
        neg_r <= a_i[63] ^ b_i[63];
        pay_r <= pay_i;
      end
    end

    assign va   = va_r;
    assign am   = am_r;
    assign bm   = bm_r;
    assign nega = neg_r;
    assign paya = pay_r;
  end else begin : g_unsigned
    assign va   = valid_i;
    assign am   = a_i;
    assign bm   = b_i;
    assign nega = 1'b0;
    assign paya = pay_i;
  end

  // Partial products of the 32-bit halves.
  logic          vb_r;
  word_t         ll_r;
  word_t         lh_r;
  word_t         hl_r;
  word_t         hh_r;
  logic          negb_r;
  logic [PW-1:0] payb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ce) begin
      vb_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ll_r   <= am[31:0] * bm[31:0];
      lh_r   <= am[31:0] * bm[63:32];
      hl_r   <= am[63:32] * bm[31:0];
      hh_r   <= am[63:32] * bm[63:32];
      negb_r <= nega;
      payb_r <= paya;
    end
  end

  // Sum the partials, add the rounding bit and shift.
  logic [127:0]  sum_c;
  logic          vc_r;
  word_t         mag_r;
  logic          negc_r;
  logic [PW-1:0] payc_r;

  assign sum_c = {hh_r, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (ce) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r  <= sum_c[SH +: 64];
      negc_r <= negb_r;
      payc_r <= payb_r;
    end
  end

  assign valid_o = vc_r;
  assign pay_o   = payc_r;
  assign res_o   = SGN ? with_sign(negc_r, mag_r) : mag_r;

endmodule

// ===== design/gte_cordic.sv =====
// Rotation-mode CORDIC, one register stage per rotation, giving cosine and sine in Q60.
// Carries a payload and a valid bit alongside. Depends on gte_pkg.
module gte_cordic #(
  parameter int unsigned    STAGES = 32,
  parameter int unsigned    PW     = 1,
  parameter gte_pkg::word_t START  = 64'd0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              valid_i,
  input  gte_pkg::word_t    z_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output gte_pkg::word_t    x_o,
  output gte_pkg::word_t    y_o,
  output logic [PW-1:0]     pay_o
);
  import gte_pkg::*;

  logic          v_r [STAGES];
  sword_t        x_r [STAGES];
  sword_t        y_r [STAGES];
  sword_t        z_r [STAGES];
  logic [PW-1:0] p_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam sword_t AT = atan_q60(s);

    logic          vp;
    sword_t        xp;
    sword_t        yp;
    sword_t        zp;
    logic [PW-1:0] pp;

    if (s == 0) begin : g_first
      assign vp = valid_i;
      assign xp = sword_t'(START);
      assign yp = '0;
      assign zp = sword_t'(z_i);
      assign pp = pay_i;
    end else begin : g_next
      assign vp = v_r[s-1];
      assign xp = x_r[s-1];
      assign yp = y_r[s-1];
      assign zp = z_r[s-1];
      assign pp = p_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (ce) begin
        v_r[s] <= vp;
      end
    end

    // Rotate toward zero residual angle.
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zp[63]) begin
          x_r[s] <= xp - (yp >>> s);
          y_r[s] <= yp + (xp >>> s);
          z_r[s] <= zp - AT;
        end else begin
          x_r[s] <= xp + (yp >>> s);
          y_r[s] <= yp - (xp >>> s);
          z_r[s] <= zp + AT;
        end
        p_r[s] <= pp;
      end
    end
  end

  assign valid_o = v_r[STAGES-1];
  assign x_o     = word_t'(x_r[STAGES-1]);
  assign y_o     = word_t'(y_r[STAGES-1]);
  assign pay_o   = p_r[STAGES-1];

endmodule

// ===== design/gte_rsqrt.sv =====
// Inverse square root of w2 in Q54 by a fixed chain of unrolled Newton steps.
// Each step uses three pipelined multipliers. Depends on gte_pkg and gte_mulr.
module gte_rsqrt #(
  parameter int unsigned PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              valid_i,
  input  gte_pkg::word_t    w2_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output gte_pkg::word_t    r_o,
  output logic [PW-1:0]     pay_o
);
  import gte_pkg::*;

  logic          v_w [NEWTON_STEPS+1];
  word_t         r_w [NEWTON_STEPS+1];
  word_t         w_w [NEWTON_STEPS+1];
  logic [PW-1:0] p_w [NEWTON_STEPS+1];

  assign v_w[0] = valid_i;
  assign r_w[0] = ONE_Q54;
  assign w_w[0] = w2_i;
  assign p_w[0] = pay_i;

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    logic             vt;
    word_t            t;
    logic [PW+127:0]  pt;
    logic             vu;
    word_t            u;
    logic [PW+127:0]  pu;
    logic [PW+63:0]   pr;

    // t = w2 * r
    gte_mulr #(.SH(60), .PW(PW + 128), .SGN(1'b0)) u_t (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .valid_i(v_w[i]), .a_i(w_w[i]), .b_i(r_w[i]),
      .pay_i({w_w[i], r_w[i], p_w[i]}),
      .valid_o(vt), .res_o(t), .pay_o(pt)
    );

    // u = t * r
    gte_mulr #(.SH(54), .PW(PW + 128), .SGN(1'b0)) u_u (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .valid_i(vt), .a_i(t), .b_i(pt[PW +: 64]),
      .pay_i(pt),
      .valid_o(vu), .res_o(u), .pay_o(pu)
    );

    // r' = r * (3 - u) / 2
    gte_mulr #(.SH(55), .PW(PW + 64), .SGN(1'b0)) u_r (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .valid_i(vu), .a_i(pu[PW +: 64]), .b_i(THREE_Q54 - u),
      .pay_i({pu[PW+64 +: 64], pu[PW-1:0]}),
      .valid_o(v_w[i+1]), .res_o(r_w[i+1]), .pay_o(pr)
    );

    assign w_w[i+1] = pr[PW +: 64];
    assign p_w[i+1] = pr[PW-1:0];
  end

  assign valid_o = v_w[NEWTON_STEPS];
  assign r_o     = r_w[NEWTON_STEPS];
  assign pay_o   = p_w[NEWTON_STEPS];

endmodule

// ===== design/geodetic_to_ecef_core.sv =====
// Top level of the geodetic to earth-centred Cartesian conversion core.
// Depends on gte_pkg, gte_mulr, gte_cordic and gte_rsqrt.
//
//  Channel | Ports                      | Contents
//  --------+----------------------------+------------------------------------------
//  input   | in_tvalid/tready/tdata     | lat_angle, lon_angle, height_mm
//  output  | out_tvalid/tready/tdata    | ecef_x_mm, ecef_y_mm, ecef_z_mm
//  config  | cfg_we/cfg_addr/cfg_wdata  | semi_major_axis_mm, ecc_squared_q40
//
// One item enters per cycle while the pipeline advances; the deepest section is the
// Newton chain for the prime-vertical radius (24 steps of three multipliers).
// Reset is synchronous; it clears valid bits and sets the configuration registers to defaults.
// The whole pipeline holds while the output register is full and not taken and
// the last stage holds an item; otherwise it advances and bubbles drain.
module geodetic_to_ecef_core #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // Fields from bit 0: lat_angle[31:0], lon_angle[63:32], height_mm[91:64]
  input  logic [95:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: ecef_x_mm[33:0], ecef_y_mm[67:34], ecef_z_mm[101:68]
  output logic [103:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [gte_pkg::CFG_W-1:0] cfg_wdata
);
  import gte_pkg::*;

  localparam word_t START = cordic_start(CORDIC_STAGES);

  typedef struct packed {
    sword_t                       sin_lat;
    sword_t                       cos_lat;
    sword_t                       sin_lon;
    sword_t                       cos_lon;
    logic signed [HEIGHT_W-1:0]   h;
  } trig_t;

  localparam int unsigned TW = $bits(trig_t);

  // Configuration registers.
  logic [AXIS_W-1:0] axis_r;
  logic [ECC_W-1:0]  ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_RESET;
      ecc_r  <= ECC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SEMI_MAJOR: axis_r <= cfg_wdata[AXIS_W-1:0];
        CFG_ECC_SQ:     ecc_r  <= cfg_wdata[ECC_W-1:0];
        default:        ;
      endcase
    end
  end

  // Pipeline advance.
  logic tail_valid;
  logic out_valid_r;
  logic ce;

  assign ce        = !tail_valid || !out_valid_r || out_tready;
  assign in_tready = ce;

  // Angle folding: quadrants two and three turn by half a turn.
  logic [ANGLE_W-1:0]  lat;
  logic [ANGLE_W-1:0]  lon;
  logic [HEIGHT_W-1:0] hin;
  logic                flip_lat;
  logic                flip_lon;
  logic [ANGLE_W-1:0]  sa_lat;
  logic [ANGLE_W-1:0]  sa_lon;

  assign lat      = in_tdata[31:0];
  assign lon      = in_tdata[63:32];
  assign hin      = in_tdata[91:64];
  assign flip_lat = lat[31] ^ lat[30];
  assign flip_lon = lon[31] ^ lon[30];
  assign sa_lat   = {lat[31] ^ flip_lat, lat[30:0]};
  assign sa_lon   = {lon[31] ^ flip_lon, lon[30:0]};

  // Binary angle to radians in Q60.
  logic                zv;
  word_t               z_lat;
  word_t               z_lon;
  logic [HEIGHT_W+1:0] zpay;

  gte_mulr #(.SH(32), .PW(HEIGHT_W + 2), .SGN(1'b1)) u_zlat (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(in_tvalid), .a_i({{32{sa_lat[31]}}, sa_lat}), .b_i(PI_Q61),
    .pay_i({hin, flip_lat, flip_lon}),
    .valid_o(zv), .res_o(z_lat), .pay_o(zpay)
  );

  gte_mulr #(.SH(32), .PW(1), .SGN(1'b1)) u_zlon (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(in_tvalid), .a_i({{32{sa_lon[31]}}, sa_lon}), .b_i(PI_Q61),
    .pay_i(1'b0),
    .valid_o(), .res_o(z_lon), .pay_o()
  );

  // Sine and cosine of both angles.
  logic                cv;
  word_t               xl;
  word_t               yl;
  word_t               xo;
  word_t               yo;
  logic [HEIGHT_W+1:0] cpay;

  gte_cordic #(.STAGES(CORDIC_STAGES), .PW(HEIGHT_W + 2), .START(START)) u_cordic_lat (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(zv), .z_i(z_lat), .pay_i(zpay),
    .valid_o(cv), .x_o(xl), .y_o(yl), .pay_o(cpay)
  );

  gte_cordic #(.STAGES(CORDIC_STAGES), .PW(1), .START(START)) u_cordic_lon (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(zv), .z_i(z_lon), .pay_i(1'b0),
    .valid_o(), .x_o(xo), .y_o(yo), .pay_o()
  );

  trig_t trig0;

  always_comb begin
    trig0.sin_lat = sword_t'(cpay[1] ? (64'd0 - yl) : yl);
    trig0.cos_lat = sword_t'(cpay[1] ? (64'd0 - xl) : xl);
    trig0.sin_lon = sword_t'(cpay[0] ? (64'd0 - yo) : yo);
    trig0.cos_lon = sword_t'(cpay[0] ? (64'd0 - xo) : xo);
    trig0.h       = cpay[HEIGHT_W+1:2];
  end

  // sin^2 of latitude, then e2 * sin^2.
  logic  s2v;
  word_t s2;
  trig_t trig1;

  gte_mulr #(.SH(60), .PW(TW), .SGN(1'b1)) u_s2 (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(cv), .a_i(word_t'(trig0.sin_lat)), .b_i(word_t'(trig0.sin_lat)),
    .pay_i(trig0),
    .valid_o(s2v), .res_o(s2), .pay_o(trig1)
  );

  logic  ev;
  word_t e2s2;
  trig_t trig2;

  gte_mulr #(.SH(40), .PW(TW), .SGN(1'b0)) u_e2s2 (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(s2v), .a_i({24'd0, ecc_r}), .b_i(s2),
    .pay_i(trig1),
    .valid_o(ev), .res_o(e2s2), .pay_o(trig2)
  );

  // w2 = 1 - e2 sin^2, floored at 2^-16.
  word_t w2;
  assign w2 = (e2s2 >= (ONE_Q60 - W2_FLOOR)) ? W2_FLOOR : (ONE_Q60 - e2s2);

  logic  rv;
  word_t r;
  trig_t trig3;

  gte_rsqrt #(.PW(TW)) u_rsqrt (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(ev), .w2_i(w2), .pay_i(trig2),
    .valid_o(rv), .r_o(r), .pay_o(trig3)
  );

  // Prime-vertical radius N and N (1 - e2), both Q20 mm.
  logic  nv;
  word_t n;
  trig_t trig4;

  gte_mulr #(.SH(34), .PW(TW), .SGN(1'b0)) u_n (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(rv), .a_i({31'd0, axis_r}), .b_i(r),
    .pay_i(trig3),
    .valid_o(nv), .res_o(n), .pay_o(trig4)
  );

  logic  nzv;
  word_t nz;
  word_t n5;
  trig_t trig5;

  gte_mulr #(.SH(40), .PW(TW + 64), .SGN(1'b0)) u_nz (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(nv), .a_i(n), .b_i(ONE_Q40 - {24'd0, ecc_r}),
    .pay_i({n, trig4}),
    .valid_o(nzv), .res_o(nz), .pay_o({n5, trig5})
  );

  // Add height in Q20.
  word_t h_q20;
  word_t nh;
  word_t zh;

  assign h_q20 = {{(64 - HEIGHT_W - 20){trig5.h[HEIGHT_W-1]}}, trig5.h, 20'd0};
  assign nh    = n5 + h_q20;
  assign zh    = nz + h_q20;

  // p = (N + h) cos(lat); the Z operands ride along through one multiplier.
  logic         pv;
  word_t        p;
  logic [255:0] ppay;

  gte_mulr #(.SH(60), .PW(256), .SGN(1'b1)) u_p (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(nzv), .a_i(nh), .b_i(word_t'(trig5.cos_lat)),
    .pay_i({zh, trig5.sin_lat, trig5.sin_lon, trig5.cos_lon}),
    .valid_o(pv), .res_o(p), .pay_o(ppay)
  );

  // Final products for X, Y and Z.
  word_t xq;
  word_t yq;
  word_t zq;

  gte_mulr #(.SH(60), .PW(1), .SGN(1'b1)) u_x (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(pv), .a_i(p), .b_i(ppay[63:0]), .pay_i(1'b0),
    .valid_o(tail_valid), .res_o(xq), .pay_o()
  );

  gte_mulr #(.SH(60), .PW(1), .SGN(1'b1)) u_y (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(pv), .a_i(p), .b_i(ppay[127:64]), .pay_i(1'b0),
    .valid_o(), .res_o(yq), .pay_o()
  );

  gte_mulr #(.SH(60), .PW(1), .SGN(1'b1)) u_z (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(pv), .a_i(ppay[255:192]), .b_i(ppay[191:128]), .pay_i(1'b0),
    .valid_o(), .res_o(zq), .pay_o()
  );

  // Output register with millimetre rounding and saturation.
  logic [103:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce && tail_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && tail_valid) begin
      out_data_r <= {2'b00, to_mm(zq), to_mm(yq), to_mm(xq)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/gte_checker.sv =====
// Port-level checker for the conversion core, bound to the top level.
// Depends only on the top level's ports.
module gte_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item dropped or changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // With the output register empty the pipeline must accept.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A result taken this cycle frees the pipeline.
  a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while a result item is taken");

endmodule

bind geodetic_to_ecef_core gte_checker u_gte_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
